@@ hdl/llm_pkg.sv @@
// ----------------------------------------------------------------------------
// llm_pkg
// Shared widths, constants and the cosine table generator for the
// lat/lon to local metres converter.
// ----------------------------------------------------------------------------
`default_nettype none

package llm_pkg;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int EAST_W  = 37;
    localparam int NORTH_W = 36;

    // quarter turn in units of 5e-8 degree, and half a turn
    localparam logic [30:0] QUARTER = 31'd1800000000;
    localparam logic [31:0] HALF    = 32'd3600000000;
    // floor(2^62 / QUARTER)
    localparam logic [31:0] RECIP_Q = 32'd2562047788;

    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    // rounded divide by 160000000 = 2^11 * 78125
    localparam logic [57:0] DIV_HALF  = 58'd80000000;
    localparam int          DIV_SHIFT = 11;
    localparam logic [16:0] DIV_ODD   = 17'd78125;
    // floor(2^47 / 78125)
    localparam logic [30:0] DIV_RECIP = 31'd1801439850;

    localparam logic signed [57:0] LAT_BASE = 58'sd111132954 <<< 30;
    localparam logic signed [51:0] LAT_C2   = 52'sd559822;
    localparam logic signed [42:0] LAT_C4   = 43'sd1175;
    localparam logic signed [57:0] LON_C    = 58'sd111132950;

    localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;

    // Q62 product with 64-bit wrap
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // entry k of a quarter-wave cosine table of 2^bits steps, unsigned Q1.30
    function automatic logic [30:0] cos_entry(input int k, input int bits);
        logic [63:0] step;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] rnd;
        step = PI_Q62 >> (bits + 1);
        x    = step * 64'(k);
        x2   = mul_q62(x, x);
        term = 64'd1 << 62;
        sum  = term;
        term = mul_q62(term, x2) / 64'd2;   sum = sum - term;
        term = mul_q62(term, x2) / 64'd12;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd30;  sum = sum - term;
        term = mul_q62(term, x2) / 64'd56;  sum = sum + term;
        term = mul_q62(term, x2) / 64'd90;  sum = sum - term;
        term = mul_q62(term, x2) / 64'd132; sum = sum + term;
        term = mul_q62(term, x2) / 64'd182; sum = sum - term;
        term = mul_q62(term, x2) / 64'd240; sum = sum + term;
        term = mul_q62(term, x2) / 64'd306; sum = sum - term;
        term = mul_q62(term, x2) / 64'd380; sum = sum + term;
        term = mul_q62(term, x2) / 64'd462; sum = sum - term;
        term = mul_q62(term, x2) / 64'd552; sum = sum + term;
        rnd  = sum + (64'd1 << 31);
        if (sum[63])
        begin
            return 31'd0;
        end
        return rnd[62:32];
    endfunction

endpackage

`default_nettype wire

@@ hdl/llm_ifs.sv @@
// ----------------------------------------------------------------------------
// llm_ifs
// Valid/ready channels for coordinate pairs in and offsets out.
// ----------------------------------------------------------------------------
`default_nettype none

interface llm_coord_if import llm_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] ref_latitude;
    logic signed [LON_W-1:0] ref_longitude;
    logic signed [LAT_W-1:0] point_latitude;
    logic signed [LON_W-1:0] point_longitude;

    modport source (output valid, ref_latitude, ref_longitude, point_latitude,
                    point_longitude, input ready);
    modport sink   (input valid, ref_latitude, ref_longitude, point_latitude,
                    point_longitude, output ready);
endinterface

interface llm_offset_if import llm_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [EAST_W-1:0]  east_mm;
    logic signed [NORTH_W-1:0] north_mm;

    modport source (output valid, east_mm, north_mm, input ready);
    modport sink   (input valid, east_mm, north_mm, output ready);
endinterface

`default_nettype wire

@@ hdl/llm_cos.sv @@
// ----------------------------------------------------------------------------
// llm_cos
// Cosine of the mid latitude sum, Q2.30, by table lookup and linear
// interpolation; eight register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module llm_cos import llm_pkg::*;
#(
    parameter int TB = 10
)
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] s,
    output logic signed [31:0] cos_q30
);

    localparam int TAB_LAST = 2 ** TB;
    localparam int IW       = TB + 1;
    localparam int PW       = TB + 48;
    localparam int QW       = TB + 17;

    typedef logic [30:0] tab_t [0:TAB_LAST];

    function automatic tab_t build_tab();
        tab_t t;
        for (int k = 0; k <= TAB_LAST; k++)
        begin
            t[k] = cos_entry(k, TB);
        end
        return t;
    endfunction

    localparam tab_t COS_TAB = build_tab();

    // fold to [0, quarter turn]
    logic [31:0] abs_s;
    logic        flip_next;
    logic [30:0] b_next;
    assign abs_s     = s[32] ? 32'(-s) : s[31:0];
    assign flip_next = abs_s > {1'b0, QUARTER};
    assign b_next    = flip_next ? 31'(HALF - abs_s) : abs_s[30:0];

    logic [30:0]   b_a_reg, b_1_reg, b_2_reg, b_3_reg;
    logic          flip_a_reg, flip_1_reg, flip_2_reg, flip_3_reg, flip_4_reg;
    logic          flip_5_reg, flip_6_reg;
    logic [62:0]   m_reg;
    logic [QW-1:0] q0_2_reg, q0_3_reg, pos_reg;
    logic [PW-1:0] prod_reg;
    logic [30:0]   t0_reg, t1_reg, t0_6_reg;
    logic [15:0]   f_reg;
    logic [46:0]   dprod_reg;
    logic [31:0]   cos_reg;

    // position = b * 2^(TB+16) / quarter, reciprocal estimate then one fix-up
    logic [PW-1:0] lhs;
    logic [PW-1:0] rem;
    logic [QW-1:0] pos_next;
    assign lhs      = PW'({b_3_reg, {(TB + 16){1'b0}}});
    assign rem      = lhs - prod_reg;
    assign pos_next = (rem >= PW'(QUARTER)) ? q0_3_reg + QW'(1) : q0_3_reg;

    logic [IW-1:0] idx0, idx1;
    assign idx0 = pos_reg[TB+16:16];
    assign idx1 = (idx0 == IW'(TAB_LAST)) ? idx0 : idx0 + IW'(1);

    logic [30:0] d;
    logic [46:0] corr_w;
    logic [30:0] mag;
    assign d      = (t0_reg > t1_reg) ? t0_reg - t1_reg : 31'd0;
    assign corr_w = (dprod_reg + 47'd32768) >> 16;
    assign mag    = t0_6_reg - corr_w[30:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_a_reg    <= b_next;
            flip_a_reg <= flip_next;

            m_reg      <= {32'd0, b_a_reg} * {31'd0, RECIP_Q};
            b_1_reg    <= b_a_reg;
            flip_1_reg <= flip_a_reg;

            q0_2_reg   <= m_reg[46-TB +: QW];
            b_2_reg    <= b_1_reg;
            flip_2_reg <= flip_1_reg;

            prod_reg   <= PW'(q0_2_reg) * PW'(QUARTER);
            q0_3_reg   <= q0_2_reg;
            b_3_reg    <= b_2_reg;
            flip_3_reg <= flip_2_reg;

            pos_reg    <= pos_next;
            flip_4_reg <= flip_3_reg;

            t0_reg     <= COS_TAB[idx0];
            t1_reg     <= COS_TAB[idx1];
            f_reg      <= pos_reg[15:0];
            flip_5_reg <= flip_4_reg;

            dprod_reg  <= {16'd0, d} * {31'd0, f_reg};
            t0_6_reg   <= t0_reg;
            flip_6_reg <= flip_5_reg;

            cos_reg    <= flip_6_reg ? -{1'b0, mag} : {1'b0, mag};
        end
    end

    assign cos_q30 = $signed(cos_reg);

endmodule

`default_nettype wire

@@ hdl/llm_div.sv @@
// ----------------------------------------------------------------------------
// llm_div
// Signed divide by 160000000, rounded half away from zero; five stages,
// reciprocal multiply in two partial products with one correction step.
// ----------------------------------------------------------------------------
`default_nettype none

module llm_div import llm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [57:0] num,
    output logic signed [30:0] quo
);

    logic [57:0] mag_in;
    logic [57:0] mplus;
    assign mag_in = num[57] ? 58'(-num) : 58'(num);
    assign mplus  = mag_in + DIV_HALF;

    logic [46:0] x_1_reg, x_2_reg, x_3_reg, x_4_reg;
    logic        neg_1_reg, neg_2_reg, neg_3_reg, neg_4_reg;
    logic [53:0] ph_reg;
    logic [54:0] pl_reg;
    logic [30:0] q0_3_reg, q0_4_reg;
    logic [47:0] qm_reg;
    logic [30:0] quo_reg;

    logic [77:0] sum;
    assign sum = {ph_reg, 24'd0} + 78'(pl_reg);

    logic [47:0] rem;
    logic [30:0] q;
    assign rem = {1'b0, x_4_reg} - qm_reg;
    assign q   = (rem >= 48'(DIV_ODD)) ? q0_4_reg + 31'd1 : q0_4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_1_reg   <= mplus[57:DIV_SHIFT];
            neg_1_reg <= num[57];

            ph_reg    <= {31'd0, x_1_reg[46:24]} * {23'd0, DIV_RECIP};
            pl_reg    <= {31'd0, x_1_reg[23:0]} * {24'd0, DIV_RECIP};
            x_2_reg   <= x_1_reg;
            neg_2_reg <= neg_1_reg;

            q0_3_reg  <= sum[77:47];
            x_3_reg   <= x_2_reg;
            neg_3_reg <= neg_2_reg;

            qm_reg    <= {17'd0, q0_3_reg} * {31'd0, DIV_ODD};
            q0_4_reg  <= q0_3_reg;
            x_4_reg   <= x_3_reg;
            neg_4_reg <= neg_3_reg;

            quo_reg   <= neg_4_reg ? -q : q;
        end
    end

    assign quo = $signed(quo_reg);

endmodule

`default_nettype wire

@@ hdl/latlon_to_local_meters.sv @@
// ----------------------------------------------------------------------------
// latlon_to_local_meters
// Flat-earth east/north offset in millimetres of a point from a reference.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  coords   | in  | ref_latitude, ref_longitude, point_latitude, point_longitude
//  offset   | out | east_mm, north_mm
//
//  one transfer in per cycle while the output is not stalled, through 22 register
//  stages; the depth is set by the input sums (1), the cosine lookup (8 stages),
//  double-angle and scale terms (6), the rounded divide (5) and the offset
//  multiply and rounding (2)
//  reset clears only the stage valid bits; the table is constant logic
//  a stalled output freezes the whole pipe, nothing is dropped or repeated
// ----------------------------------------------------------------------------
`default_nettype none

module latlon_to_local_meters import llm_pkg::*;
#(
    parameter int COS_TABLE_BITS = 10
)
(
    input  logic         clk,
    input  logic         rst_n,
    llm_coord_if.sink    coords,
    llm_offset_if.source offset
);

    localparam int DEPTH    = 22;
    localparam int DIFF_DLY = 19;
    localparam int LON_DLY  = 5;

    logic en;
    logic [DEPTH-1:0] vld_reg;

    assign en           = !vld_reg[DEPTH-1] || offset.ready;
    assign coords.ready = en;
    assign offset.valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], coords.valid};
        end
    end

    logic signed [32:0] s_reg;
    logic signed [31:0] dlat_reg;
    logic signed [32:0] dlon_reg;
    logic signed [31:0] dlat_dly_reg [DIFF_DLY];
    logic signed [32:0] dlon_dly_reg [DIFF_DLY];

    logic signed [31:0] cos_q30;

    llm_cos #(.TB(COS_TABLE_BITS)) u_cos (
        .clk     (clk),
        .en      (en),
        .s       (s_reg),
        .cos_q30 (cos_q30)
    );

    logic [60:0]        sq_reg, sq2_reg;
    logic signed [57:0] lonnum_reg [LON_DLY+1];
    logic signed [31:0] c2_reg, c2_3_reg, c2_4_reg, c4_reg;
    logic signed [51:0] p2_reg;
    logic signed [42:0] p4_reg;
    logic signed [57:0] latnum_reg;

    logic signed [61:0] sq_w, sq2_w;
    logic [60:0]        sq_rnd, sq2_rnd;
    assign sq_w    = 62'(cos_q30) * 62'(cos_q30);
    assign sq2_w   = 62'(c2_reg) * 62'(c2_reg);
    assign sq_rnd  = sq_reg + 61'd268435456;
    assign sq2_rnd = sq2_reg + 61'd268435456;

    logic signed [30:0] lon_q, lat_q;

    llm_div u_div_lon (
        .clk (clk),
        .en  (en),
        .num (lonnum_reg[LON_DLY]),
        .quo (lon_q)
    );

    llm_div u_div_lat (
        .clk (clk),
        .en  (en),
        .num (latnum_reg),
        .quo (lat_q)
    );

    logic signed [63:0] pe_reg;
    logic signed [62:0] pn_reg;
    logic [EAST_W-1:0]  east_reg;
    logic [NORTH_W-1:0] north_reg;

    // offsets rounded half away from zero to millimetres
    logic [63:0] e_mag, e_rnd;
    logic [62:0] n_mag, n_rnd;
    assign e_mag = pe_reg[63] ? 64'(-pe_reg) : 64'(pe_reg);
    assign e_rnd = (e_mag + 64'd33554432) >> 26;
    assign n_mag = pn_reg[62] ? 63'(-pn_reg) : 63'(pn_reg);
    assign n_rnd = (n_mag + 63'd33554432) >> 26;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= 33'(coords.ref_latitude) + 33'(coords.point_latitude);
            dlat_reg <= 32'(coords.point_latitude) - 32'(coords.ref_latitude);
            dlon_reg <= 33'(coords.point_longitude) - 33'(coords.ref_longitude);

            dlat_dly_reg[0] <= dlat_reg;
            dlon_dly_reg[0] <= dlon_reg;
            for (int i = 1; i < DIFF_DLY; i++)
            begin
                dlat_dly_reg[i] <= dlat_dly_reg[i-1];
                dlon_dly_reg[i] <= dlon_dly_reg[i-1];
            end

            sq_reg        <= sq_w[60:0];
            lonnum_reg[0] <= 58'(cos_q30) * LON_C;
            for (int i = 1; i <= LON_DLY; i++)
            begin
                lonnum_reg[i] <= lonnum_reg[i-1];
            end

            // double angle: 2c^2 - 1
            c2_reg     <= $signed(32'(sq_rnd >> 29)) - Q30_ONE;
            sq2_reg    <= sq2_w[60:0];
            c2_3_reg   <= c2_reg;
            c4_reg     <= $signed(32'(sq2_rnd >> 29)) - Q30_ONE;
            c2_4_reg   <= c2_3_reg;
            p2_reg     <= 52'(c2_4_reg) * LAT_C2;
            p4_reg     <= 43'(c4_reg) * LAT_C4;
            latnum_reg <= LAT_BASE - 58'(p2_reg) + 58'(p4_reg);

            pe_reg    <= 64'(dlon_dly_reg[DIFF_DLY-1]) * 64'(lon_q);
            pn_reg    <= 63'(dlat_dly_reg[DIFF_DLY-1]) * 63'(lat_q);

            east_reg  <= pe_reg[63] ? EAST_W'(-e_rnd) : EAST_W'(e_rnd);
            north_reg <= pn_reg[62] ? NORTH_W'(-n_rnd) : NORTH_W'(n_rnd);
        end
    end

    assign offset.east_mm  = $signed(east_reg);
    assign offset.north_mm = $signed(north_reg);

endmodule

`default_nettype wire

@@ hdl/llm_checker.sv @@
// ----------------------------------------------------------------------------
// llm_checker
// Port-level checks on the converter's handshakes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module llm_checker import llm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [EAST_W-1:0]  east_mm,
    input logic signed [NORTH_W-1:0] north_mm
);

    // input side only stalls behind a waiting result
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output stall");

    // nothing leaves while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(east_mm) && $stable(north_mm))
        else $error("result changed while stalled");

    // a stall also freezes the input side, so no transfer in can slip past
    a_no_in_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !(in_valid && in_ready))
        else $error("input taken while output stalled");

endmodule

bind latlon_to_local_meters llm_checker u_llm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coords.valid),
    .in_ready  (coords.ready),
    .out_valid (offset.valid),
    .out_ready (offset.ready),
    .east_mm   (offset.east_mm),
    .north_mm  (offset.north_mm)
);

`default_nettype wire
